@@ rtl/ows_pkg.sv @@
// Shared types and constants for the oscillator waveform shaper.
// Holds the waveform codes, 16.16 constants and the reciprocal factors
// used for the divisions by constants. No dependencies.
`default_nettype none

package ows_pkg;

    typedef enum logic [2:0] {
        ACT_TRIANGLE = 3'd0,
        ACT_TILT_SAW = 3'd1,
        ACT_SAW      = 3'd2,
        ACT_SQUARE   = 3'd3,
        ACT_PULSE    = 3'd4,
        ACT_ORGAN    = 3'd5,
        ACT_NOISE    = 3'd6,
        ACT_PHASER   = 3'd7
    } t_action;

    localparam int PHASE_W  = 31;
    localparam int SAMPLE_W = 17;
    // Phase bits actually used: fraction plus the slow modulator window.
    localparam int PH_KEEP_W = 23;

    // 16.16 constants, truncated.
    localparam logic [15:0]        FX_THIRDISH = 16'd21843;
    localparam logic [15:0]        FX_KNEE     = 16'd58982;
    localparam logic signed [16:0] FX_SAWGAIN  = 17'sd42795;
    localparam logic signed [20:0] FX_QTR      = 21'sd16384;

    // floor(t * 2^16 / 29491) == (t * TILT_RECIP) >> 31 for t below the knee.
    localparam logic [32:0] TILT_RECIP = 33'd4772218249;
    localparam int          TILT_SHIFT = 31;
    // Half of (1 - knee): the falling edge divides by this.
    localparam int          TILT_REST_HALF = 3277;
    // floor(x / 9) == (x * ORGAN_RECIP) >> 21 for x below 2^18.
    localparam logic [17:0] ORGAN_RECIP = 18'd233017;
    // floor(x / 3) == (x * PHASER_RECIP) >> 19 for x below 2^18.
    localparam logic [17:0] PHASER_RECIP = 18'd174763;

    function automatic logic [20:0] abs21(input logic signed [20:0] v);
        return v[20] ? 21'(-v) : 21'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ows_shape.sv @@
// Waveform shaping logic: one sample from a waveform code and the phase.
// Purely combinational; sits between the input and result registers.
// Depends on ows_pkg.
`default_nettype none

module ows_shape
    import ows_pkg::*;
(
    input  var t_action                 i_action,
    input  wire logic [PH_KEEP_W-1:0]   i_phase,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    logic [15:0]        t;
    logic [15:0]        m;

    logic signed [20:0] tri_d;
    logic signed [20:0] tri_v;

    logic [48:0]        tilt_p;
    logic [16:0]        tilt_q1;
    logic [12:0]        tilt_w;
    logic [14:0]        tilt_w4;
    logic [3:0]         tilt_c;
    logic [17:0]        tilt_q2;
    logic signed [20:0] tilt_rise;
    logic signed [20:0] tilt_fall;
    logic signed [20:0] tilt_v;

    logic signed [32:0] saw_p;

    logic [20:0]        t24;
    logic signed [20:0] org_lo;
    logic signed [20:0] org_hi;
    logic signed [20:0] org_r;
    logic [20:0]        org_a;
    logic [35:0]        org_p;
    logic [14:0]        org_q;
    logic signed [20:0] org_v;

    logic [20:0]        ph_k;
    logic [15:0]        ph_kh;
    logic [15:0]        ph_u;
    logic [20:0]        ph_d1;
    logic [20:0]        ph_d2;
    logic signed [20:0] ph_r;
    logic [20:0]        ph_a;
    logic [35:0]        ph_p;
    logic [16:0]        ph_q;
    logic signed [20:0] ph_v;

    logic signed [20:0] res;

    assign t = i_phase[15:0];
    assign m = i_phase[22:7];

    // Triangle: floor((|4t - 2| - 1) / 2)
    assign tri_d = $signed(21'({t, 2'b00})) - 21'sd131072;
    assign tri_v = $signed(abs21(tri_d)) - 21'sd65536;

    // Tilted saw, rising edge: 2t / 0.9 by reciprocal.
    assign tilt_p    = 49'(t) * 49'(TILT_RECIP);
    assign tilt_q1   = tilt_p[TILT_SHIFT+16:TILT_SHIFT];
    assign tilt_rise = $signed(21'(tilt_q1)) - 21'sd65536;

    // Falling edge: w * 2^16 / 3277 = 20w - ceil(4w / 3277), w = 1 - t.
    assign tilt_w  = 13'(17'h10000 - {1'b0, t});
    assign tilt_w4 = {tilt_w, 2'b00};

    always_comb begin
        tilt_c = '0;
        for (int k = 0; k < 8; k++) begin
            if (tilt_w4 > 15'(k * TILT_REST_HALF)) begin
                tilt_c = tilt_c + 4'd1;
            end
        end
    end

    assign tilt_q2   = 18'(tilt_w) * 18'd20 - 18'(tilt_c);
    assign tilt_fall = $signed(21'(tilt_q2)) - 21'sd65536;
    assign tilt_v    = (t < FX_KNEE) ? tilt_rise : tilt_fall;

    // Saw: the signed view of t is t or t - 1; floor of the 16.16 product.
    assign saw_p = 33'(FX_SAWGAIN) * 33'($signed(t));

    // Organ: two humps, then truncate towards zero over 9.
    assign t24    = 21'({t, 4'b0000}) + 21'({t, 3'b000});
    assign org_lo = 21'sd196608 - $signed(abs21($signed(t24) - 21'sd393216));
    assign org_hi = 21'sd65536
                  - $signed(abs21($signed(21'({t, 4'b0000})) - 21'sd786432));
    assign org_r  = t[15] ? org_hi : org_lo;
    assign org_a  = abs21(org_r);
    assign org_p  = 36'(org_a[17:0]) * 36'(ORGAN_RECIP);
    assign org_q  = org_p[35:21];
    assign org_v  = org_r[20] ? -$signed(21'(org_q)) : $signed(21'(org_q));

    // Phaser: slow modulator shifts a second triangle against the first.
    assign ph_k  = abs21($signed(21'({m, 1'b0})) - 21'sd65536);
    assign ph_kh = ph_k[16:1];
    assign ph_u  = t + ph_kh;
    assign ph_d1 = abs21($signed(21'({ph_u, 2'b00})) - 21'sd131072);
    assign ph_d2 = abs21($signed(21'({t, 3'b000})) - 21'sd262144);
    assign ph_r  = $signed(ph_d1) - $signed(ph_d2);
    assign ph_a  = abs21(ph_r);
    // Divide by 6 as halve then divide by 3.
    assign ph_p  = 36'(ph_a[18:1]) * 36'(PHASER_RECIP);
    assign ph_q  = ph_p[35:19];
    assign ph_v  = ph_r[20] ? -$signed(21'(ph_q)) : $signed(21'(ph_q));

    always_comb begin
        unique case (i_action)
            ACT_TRIANGLE: res = tri_v >>> 1;
            ACT_TILT_SAW: res = tilt_v >>> 1;
            ACT_SAW:      res = 21'(saw_p[32:16]);
            ACT_SQUARE:   res = t[15] ? -FX_QTR : FX_QTR;
            ACT_PULSE:    res = (t < FX_THIRDISH) ? FX_QTR : -FX_QTR;
            ACT_ORGAN:    res = org_v;
            ACT_NOISE:    res = '0;
            ACT_PHASER:   res = ph_v;
        endcase
    end

    assign o_sample = res[SAMPLE_W-1:0];

endmodule

`default_nettype wire

@@ rtl/oscillator_waveform_shaper.sv @@
// A sample passes through the input register, the shaping logic and the result
// register before it is offered on the result channel.
// Throughput: one transaction per cycle; the input stalls only when both
// registers hold data and the output is stalled.
// Reset clears the valid flags only; the data registers are not reset.
// Depends on ows_pkg and ows_shape.
`default_nettype none

module oscillator_waveform_shaper
    import ows_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [2:0]                 i_action,
    input  wire logic [PHASE_W-1:0]         i_phase,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [SAMPLE_W-1:0]      o_sample
);

    logic                         r_in_valid;
    t_action                      r_action;
    logic [PH_KEEP_W-1:0]         r_phase;
    logic                         r_out_valid;
    logic signed [SAMPLE_W-1:0]   r_sample;

    logic                         w_out_load;
    logic signed [SAMPLE_W-1:0]   w_sample;

    // Result register takes a new sample when empty or being drained.
    assign w_out_load = !r_out_valid || !i_stall;
    assign o_stall    = r_in_valid && !w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_action <= t_action'(i_action);
            r_phase  <= i_phase[PH_KEEP_W-1:0];
        end
        if (w_out_load && r_in_valid) begin
            r_sample <= w_sample;
        end
    end

    ows_shape u_shape (
        .i_action (r_action),
        .i_phase  (r_phase),
        .o_sample (w_sample)
    );

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a register is free");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted transaction lost at the input register");

    a_bubble_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && w_out_load) |=> !o_valid)
        else $error("result register shows data without a source");

    a_noise_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_load && (r_action == ACT_NOISE))
            |=> (o_valid && (o_sample == '0)))
        else $error("noise sample not zero");

endmodule

`default_nettype wire
